>>> rtl/tvmeu_pkg.sv
// types, opcodes and constants shared by the execute unit modules
// no dependencies
package tvmeu_pkg;

  localparam int MemDepth = 256;
  localparam int AddrW = $clog2(MemDepth);

  typedef struct packed {
    logic [4:0] opcode;
    logic immediate;
    logic [1:0] dest_reg;
    logic [1:0] src_reg;
    logic [7:0] address;
    logic signed [7:0] constant;
    logic [15:0] instruction_word;
    logic [31:0] read_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic [4:0] status_word;
    logic write_valid;
    logic [31:0] write_data;
    logic halted;
    logic illegal;
    logic [4:0] cycle_cost;
  } out_word_t;

  // memory port request from the control sequencer
  typedef struct packed {
    logic we;
    logic [AddrW-1:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  localparam logic [4:0] OpLoad = 5'd0;
  localparam logic [4:0] OpStore = 5'd1;
  localparam logic [4:0] OpAdd = 5'd2;
  localparam logic [4:0] OpAddc = 5'd3;
  localparam logic [4:0] OpSub = 5'd4;
  localparam logic [4:0] OpSubc = 5'd5;
  localparam logic [4:0] OpAnd = 5'd6;
  localparam logic [4:0] OpXor = 5'd7;
  localparam logic [4:0] OpCompl = 5'd8;
  localparam logic [4:0] OpShl = 5'd9;
  localparam logic [4:0] OpShla = 5'd10;
  localparam logic [4:0] OpShr = 5'd11;
  localparam logic [4:0] OpShra = 5'd12;
  localparam logic [4:0] OpCompr = 5'd13;
  localparam logic [4:0] OpGetstat = 5'd14;
  localparam logic [4:0] OpPutstat = 5'd15;
  localparam logic [4:0] OpJump = 5'd16;
  localparam logic [4:0] OpJumpl = 5'd17;
  localparam logic [4:0] OpJumpe = 5'd18;
  localparam logic [4:0] OpJumpg = 5'd19;
  localparam logic [4:0] OpCall = 5'd20;
  localparam logic [4:0] OpReturn = 5'd21;
  localparam logic [4:0] OpRead = 5'd22;
  localparam logic [4:0] OpWrite = 5'd23;
  localparam logic [4:0] OpHalt = 5'd24;
  localparam logic [4:0] OpNoop = 5'd25;

  localparam logic [4:0] CostNone = 5'd0;
  localparam logic [4:0] CostOne = 5'd1;
  localparam logic [4:0] CostMem = 5'd4;
  localparam logic [4:0] CostIo = 5'd28;

  localparam logic [31:0] SatPos = 32'd65535;
  localparam logic [31:0] SatNeg = 32'hFFFF0001;

  // clamp to +-65535, returns {carry, value}
  function automatic logic [32:0] clamp(input logic [31:0] v);
    logic [32:0] r;
    if (!v[31] && v > SatPos) r = {1'b1, SatPos};
    else if (v[31] && v < SatNeg) r = {1'b1, SatNeg};
    else r = {1'b0, v};
    return r;
  endfunction

  function automatic logic [4:0] compare(input logic [31:0] a, input logic [31:0] b,
                                         input logic [4:0] st);
    logic [4:0] r;
    if (a < b) r = (st & 5'd25) | 5'd8;
    else if (a == b) r = (st & 5'd21) | 5'd4;
    else r = (st & 5'd19) | 5'd2;
    return r;
  endfunction

endpackage

>>> rtl/tvmeu_mem.sv
// data and stack memory, one port, registered read
// depends on tvmeu_pkg
module tvmeu_mem (
  input  logic clk,
  input  tvmeu_pkg::mem_req_t req,
  output logic [31:0] rdata
);

  logic [31:0] mem [tvmeu_pkg::MemDepth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

>>> rtl/tvmeu_alu.sv
// combinational register operations: arithmetic, logic, shifts, compares, status moves
// depends on tvmeu_pkg
module tvmeu_alu (
  input  logic [4:0] opcode,
  input  logic immediate,
  input  logic [31:0] dval,
  input  logic [31:0] sval,
  input  logic [31:0] kval,
  input  logic [4:0] status,
  output logic [31:0] result,
  output logic [4:0] status_next,
  output logic legal
);

  logic [31:0] b;
  logic [32:0] cl;
  logic cin;
  logic hi;

  assign b = immediate ? kval : sval;
  assign cin = status[0];
  assign hi = (dval >> 15) == 32'd1;

  always_comb begin
    result = dval;
    status_next = status;
    legal = 1'b1;
    cl = '0;
    unique case (opcode)
      tvmeu_pkg::OpAdd, tvmeu_pkg::OpAddc, tvmeu_pkg::OpSub, tvmeu_pkg::OpSubc: begin
        unique case (opcode)
          tvmeu_pkg::OpAdd: cl = tvmeu_pkg::clamp(dval + b);
          tvmeu_pkg::OpAddc: cl = tvmeu_pkg::clamp(dval + b + {31'd0, cin});
          tvmeu_pkg::OpSub: cl = tvmeu_pkg::clamp(dval - b);
          default: cl = tvmeu_pkg::clamp(dval - b - {31'd0, cin});
        endcase
        result = cl[31:0];
        status_next = {status[4:1], cl[32]};
      end
      tvmeu_pkg::OpAnd: result = dval & b;
      tvmeu_pkg::OpXor: result = dval ^ b;
      tvmeu_pkg::OpCompr: status_next = tvmeu_pkg::compare(dval, b, status);
      default: begin
        if (immediate) begin
          legal = 1'b0;
        end else begin
          unique case (opcode)
            tvmeu_pkg::OpCompl: result = ~dval;
            tvmeu_pkg::OpShl: begin
              result = dval << 1;
              status_next = {status[4:1], hi};
            end
            tvmeu_pkg::OpShla: begin
              result = (dval << 1) | {31'd0, hi};
              status_next = {status[4:1], hi};
            end
            tvmeu_pkg::OpShr: begin
              result = dval >> 1;
              status_next = {status[4:1], dval[0]};
            end
            tvmeu_pkg::OpShra: begin
              result = (dval >> 1) | (hi ? 32'h8000 : 32'h0);
              status_next = {status[4:1], hi};
            end
            tvmeu_pkg::OpGetstat: result = {27'd0, status};
            tvmeu_pkg::OpPutstat: status_next = dval[4:0];
            default: legal = 1'b0;
          endcase
        end
      end
    endcase
  end

endmodule

>>> rtl/teaching_vm_execute_unit_core.sv
// channel   dir  handshake      payload
// in        in   in_valid/stall tvmeu_pkg::in_word_t
// out       out  out_valid/stall tvmeu_pkg::out_word_t
// one item at a time; load, call and return pass through extra states
// (StLoad, StPush, StPull), set by the single memory port (one word a cycle).
// after reset the memory is swept to zero, all 256 words, in_stall held high.
// a result waits in the output register; the next word is taken meanwhile
// and its own result waits in done until the output register is free.
// depends on tvmeu_pkg, tvmeu_alu, tvmeu_mem
module teaching_vm_execute_unit_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tvmeu_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output tvmeu_pkg::out_word_t out_data
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StPush = 3'd4;
  localparam logic [2:0] StPull = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] state;
  logic [tvmeu_pkg::AddrW:0] clr;
  tvmeu_pkg::in_word_t cur;
  logic [31:0] regs [4];
  logic [7:0] pc;
  logic [7:0] sp;
  logic [4:0] status;
  logic [15:0] saved;
  logic [63:0] clock;
  logic halt;
  logic [2:0] step;
  tvmeu_pkg::out_word_t res;
  logic wv;
  logic [31:0] wd;
  logic bad;
  logic [4:0] cost;

  tvmeu_pkg::mem_req_t req;
  logic [31:0] rdata;
  logic [31:0] dval;
  logic [31:0] sval;
  logic [31:0] kval;
  logic [31:0] alu_res;
  logic [4:0] alu_st;
  logic alu_ok;
  logic [7:0] pc1;
  logic [7:0] spu;
  logic take;

  assign dval = regs[cur.dest_reg];
  assign sval = regs[cur.src_reg];
  assign kval = {{24{cur.constant[7]}}, cur.constant};
  assign pc1 = pc + 8'd1;
  assign spu = sp + 8'd1;
  assign in_stall = state != StIdle;
  assign take = in_valid && !in_stall;
  assign out_data = res;

  tvmeu_alu u_alu (
    .opcode(cur.opcode), .immediate(cur.immediate), .dval(dval), .sval(sval),
    .kval(kval), .status(status), .result(alu_res), .status_next(alu_st), .legal(alu_ok)
  );

  tvmeu_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  // push order: status, iword, r0..r3, pc
  always_comb begin
    req.we = 1'b0;
    req.addr = sp[tvmeu_pkg::AddrW-1:0];
    req.wdata = '0;
    unique case (state)
      StClear: begin
        req.we = 1'b1;
        req.addr = clr[tvmeu_pkg::AddrW-1:0];
      end
      StExec: begin
        req.addr = cur.address[tvmeu_pkg::AddrW-1:0];
        if (!halt && cur.immediate && cur.opcode == tvmeu_pkg::OpStore) begin
          req.we = 1'b1;
          req.wdata = dval;
        end
        if (!halt && !cur.immediate && cur.opcode == tvmeu_pkg::OpReturn) begin
          req.addr = spu[tvmeu_pkg::AddrW-1:0];
        end
      end
      StPush: begin
        req.we = 1'b1;
        unique case (step)
          3'd0: req.wdata = {27'd0, status};
          3'd1: req.wdata = {16'd0, cur.instruction_word};
          3'd2: req.wdata = regs[0];
          3'd3: req.wdata = regs[1];
          3'd4: req.wdata = regs[2];
          3'd5: req.wdata = regs[3];
          default: req.wdata = {24'd0, pc};
        endcase
      end
      StPull: req.addr = spu[tvmeu_pkg::AddrW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      clr <= '0;
      pc <= '0;
      sp <= 8'd255;
      status <= '0;
      saved <= '0;
      clock <= '0;
      halt <= 1'b0;
      out_valid <= 1'b0;
      step <= '0;
      for (int i = 0; i < 4; i++) regs[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state != StDone) out_valid <= 1'b0;
      unique case (state)
        StClear: begin
          clr <= clr + 1'b1;
          if (clr == (tvmeu_pkg::AddrW+1)'(tvmeu_pkg::MemDepth - 1)) state <= StIdle;
        end
        StIdle: begin
          if (take) begin
            cur <= in_data;
            state <= StExec;
          end
        end
        StExec: begin
          wv <= 1'b0;
          wd <= '0;
          bad <= 1'b0;
          cost <= tvmeu_pkg::CostOne;
          step <= '0;
          state <= StDone;
          if (halt) begin
            cost <= tvmeu_pkg::CostNone;
          end else begin
            pc <= pc1;
            if (cur.immediate) begin
              priority case (cur.opcode)
                tvmeu_pkg::OpLoad: regs[cur.dest_reg] <= kval;
                tvmeu_pkg::OpStore: cost <= tvmeu_pkg::CostMem;
                tvmeu_pkg::OpJump: pc <= cur.address;
                tvmeu_pkg::OpJumpl: if (status[3]) pc <= cur.address;
                tvmeu_pkg::OpJumpe: if (status[2]) pc <= cur.address;
                tvmeu_pkg::OpJumpg: if (status[1]) pc <= cur.address;
                tvmeu_pkg::OpCall: state <= StPush;
                default: begin
                  if (alu_ok) begin
                    regs[cur.dest_reg] <= alu_res;
                    status <= alu_st;
                  end else begin
                    bad <= 1'b1;
                    cost <= tvmeu_pkg::CostNone;
                  end
                end
              endcase
            end else begin
              priority case (cur.opcode)
                tvmeu_pkg::OpLoad: begin
                  cost <= tvmeu_pkg::CostMem;
                  state <= StLoad;
                end
                tvmeu_pkg::OpReturn: begin
                  sp <= spu;
                  state <= StPull;
                end
                tvmeu_pkg::OpRead: begin
                  regs[cur.dest_reg] <= cur.read_value;
                  cost <= tvmeu_pkg::CostIo;
                end
                tvmeu_pkg::OpWrite: begin
                  wv <= 1'b1;
                  wd <= dval;
                  cost <= tvmeu_pkg::CostIo;
                end
                tvmeu_pkg::OpHalt: halt <= 1'b1;
                tvmeu_pkg::OpNoop: ;
                default: begin
                  if (alu_ok) begin
                    regs[cur.dest_reg] <= alu_res;
                    status <= alu_st;
                  end else begin
                    bad <= 1'b1;
                    cost <= tvmeu_pkg::CostNone;
                  end
                end
              endcase
            end
          end
        end
        StLoad: begin
          regs[cur.dest_reg] <= rdata;
          state <= StDone;
        end
        StPush: begin
          sp <= sp - 8'd1;
          step <= step + 3'd1;
          if (step == 3'd6) begin
            pc <= cur.address;
            state <= StDone;
          end
        end
        StPull: begin
          // rdata holds the word addressed last cycle
          unique case (step)
            3'd0: pc <= rdata[7:0];
            3'd1: regs[3] <= rdata;
            3'd2: regs[2] <= rdata;
            3'd3: regs[1] <= rdata;
            3'd4: regs[0] <= rdata;
            3'd5: saved <= rdata[15:0];
            default: status <= rdata[4:0];
          endcase
          step <= step + 3'd1;
          if (step == 3'd6) state <= StDone;
          else sp <= spu;
        end
        StDone: begin
          // wait while the previous word is still held in the output register
          if (!out_valid || !out_stall) begin
            clock <= clock + {59'd0, cost};
            res.next_pc <= pc;
            res.status_word <= status;
            res.write_valid <= wv;
            res.write_data <= wd;
            res.halted <= halt;
            res.illegal <= bad;
            res.cycle_cost <= cost;
            out_valid <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) take |=> state == StExec)
    else $error("accepted word did not start execution");
  assert property (@(posedge clk) disable iff (rst) state == StDone |=> out_valid)
    else $error("finished word not presented");
  assert property (@(posedge clk) disable iff (rst)
    (state == StPush && step == 3'd6) |=> (state == StDone && pc == $past(cur.address)))
    else $error("call did not jump after seven pushes");
  assert property (@(posedge clk) disable iff (rst) state == StClear |-> in_stall)
    else $error("input taken during memory clear");
  assert property (@(posedge clk) disable iff (rst) $past(halt) |-> halt)
    else $error("halt flag dropped");

endmodule
